### hdl/fbfl_pkg.sv
// Shared widths, codes and control structures of the fixed block free list allocator.
`default_nettype none

package fbfl_pkg;

	localparam int OP_W     = 1;
	localparam int BLK_W    = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;
	localparam int POOL_W   = 9;

	localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
	localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

	// Commands from the operation stage to the free list.
	typedef struct packed {
		logic              relink;
		logic              pop;
		logic              push;
		logic [BLK_W-1:0]  blk;
		logic [POOL_W-1:0] pool_blocks;
	} fl_cmd_t;

	// Free list status as seen by the operation stage. Blocks below fresh have
	// been handed out from the counter since the last relink.
	typedef struct packed {
		logic              empty;
		logic [POOL_W-1:0] head;
		logic [POOL_W-1:0] fresh;
	} fl_stat_t;

endpackage

`default_nettype wire

### hdl/fbfl_req_if.sv
// Request channel carrying one allocate or release operation per transfer.
`default_nettype none

interface fbfl_req_if import fbfl_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [BLK_W-1:0] block_index;

	modport source (output valid, output operation, output block_index, input ready);
	modport sink   (input valid, input operation, input block_index, output ready);

endinterface

`default_nettype wire

### hdl/fbfl_rsp_if.sv
// Response channel carrying one result per operation.
`default_nettype none

interface fbfl_rsp_if import fbfl_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [BLK_W-1:0]    granted_index;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  used_count;
	logic                was_occupied;

	modport source (output valid, output granted_index, output status, output used_count,
		output was_occupied, input ready);
	modport sink   (input valid, input granted_index, input status, input used_count,
		input was_occupied, output ready);

endinterface

`default_nettype wire

### hdl/fbfl_free_list.sv
// LIFO free list: a stack of released blocks in front of the never-allocated blocks.
`default_nettype none

module fbfl_free_list import fbfl_pkg::*; #(
	parameter int POOL_DEPTH = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  fl_cmd_t   cmd,
	output fl_stat_t  stat
);

	localparam int STK_DEPTH = (POOL_DEPTH < 256) ? POOL_DEPTH : 256;
	localparam int BLK_CNT   = (POOL_DEPTH < 511) ? POOL_DEPTH : 511;
	localparam int IDX_W     = $clog2(STK_DEPTH);
	localparam int SP_W      = $clog2(STK_DEPTH + 1);
	localparam int CNT_W     = $clog2(BLK_CNT + 1);

	// The top two stack entries live in registers; the rest sit in the memory,
	// and the third entry is read ahead every cycle so that pops can follow
	// one another without a gap.
	logic [IDX_W-1:0] stk_mem [STK_DEPTH];
	logic [IDX_W-1:0] top_q;
	logic [IDX_W-1:0] nxt_q;
	logic [IDX_W-1:0] rd_q;
	logic [SP_W-1:0]  sp_q;
	logic [CNT_W-1:0] fresh_q;

	logic [SP_W-1:0]  sp_d;
	logic [SP_W-1:0]  rd_ptr;
	logic [SP_W-1:0]  wr_ptr;
	logic             stk_pop;
	logic             fresh_pop;

	assign stk_pop   = cmd.pop && (sp_q != '0);
	assign fresh_pop = cmd.pop && (sp_q == '0);

	assign stat.empty = (sp_q == '0) && (POOL_W'(fresh_q) >= cmd.pool_blocks);
	assign stat.head  = (sp_q != '0) ? POOL_W'(top_q) : POOL_W'(fresh_q);
	assign stat.fresh = POOL_W'(fresh_q);

	always_comb begin
		if (cmd.relink) begin
			sp_d = '0;
		end else if (stk_pop) begin
			sp_d = sp_q - SP_W'(1);
		end else if (cmd.push) begin
			sp_d = sp_q + SP_W'(1);
		end else begin
			sp_d = sp_q;
		end
	end

	assign rd_ptr = sp_d - SP_W'(3);
	assign wr_ptr = sp_q - SP_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= '0;
			fresh_q <= '0;
		end else begin
			sp_q <= sp_d;
			if (cmd.relink) begin
				fresh_q <= '0;
			end else if (fresh_pop) begin
				fresh_q <= fresh_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= cmd.blk[IDX_W-1:0];
			nxt_q <= top_q;
		end else if (stk_pop) begin
			top_q <= nxt_q;
			nxt_q <= rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && (sp_q != '0)) begin
			stk_mem[wr_ptr[IDX_W-1:0]] <= top_q;
		end
		rd_q <= stk_mem[rd_ptr[IDX_W-1:0]];
	end

endmodule

`default_nettype wire

### hdl/fixed_block_free_list_allocator_unit.sv
// Top level of the fixed block pool allocator with a LIFO free list.
`default_nettype none

// The unit hands out and takes back block indices of a fixed pool. Each request
// transfer on req is either an allocate, which pops the head of the free list, or
// a release of block_index, which pushes that block so that it is the next one
// handed out. Every request yields exactly one response transfer on rsp with the
// granted block (zero unless an allocate succeeds), a status, the number of
// allocated blocks after the operation and whether block_index was allocated
// before it. An allocate on an empty pool, a release while nothing is allocated,
// and a release of a block that lies beyond the pool or is already free report
// their own status and leave the state untouched. Writing cfg_wdata with cfg_we
// sets the pool size (zero is taken as one, values above the depth as the depth)
// and rebuilds the free list at once, so no clearing pass is needed after reset
// or a write; writes must only be made while no request is in flight. The unit
// takes one request in every cycle while the response side keeps up. Each
// operation is held first in the input register and then in the result
// register. What makes back-to-back allocates possible is the free list itself:
// never-allocated blocks are handed out from a counter, released blocks form a
// stack whose two top entries are kept in registers while the stack memory reads
// the third entry ahead on every cycle. The occupancy bits sit in a memory that
// is read at the request transfer; an entry only counts when its block lies below
// the number of blocks handed out from the counter since the last write, so the
// occupancy memory needs no clearing pass either.
module fixed_block_free_list_allocator_unit import fbfl_pkg::*; #(
	parameter int POOL_DEPTH = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [POOL_W-1:0] cfg_wdata,
	fbfl_req_if.sink               req,
	fbfl_rsp_if.source             rsp
);

	// Only blocks below 256 can be named by a release, and a 9-bit pool size
	// never exceeds 511, so the occupancy store and the counts are sized to that.
	localparam int OCC_DEPTH = (POOL_DEPTH < 256) ? POOL_DEPTH : 256;
	localparam int BLK_CNT   = (POOL_DEPTH < 511) ? POOL_DEPTH : 511;
	localparam int IDX_W     = $clog2(OCC_DEPTH);
	localparam int CNT_W     = $clog2(BLK_CNT + 1);
	localparam logic [POOL_W-1:0] POOL_CAP = POOL_W'(BLK_CNT);
	localparam logic [POOL_W-1:0] POOL_RST = POOL_W'((POOL_DEPTH < 256) ? POOL_DEPTH : 256);

	// Configuration and bookkeeping state.
	logic [POOL_W-1:0]    pool_q;
	logic [CNT_W-1:0]     count_q;
	logic                 occ_mem [OCC_DEPTH];

	// Input register.
	logic                 valid_s1;
	logic [OP_W-1:0]      op_s1;
	logic [BLK_W-1:0]     blk_s1;
	logic                 occ_rd_s1;

	// Result register.
	logic                 valid_s2;
	logic [BLK_W-1:0]     granted_s2;
	logic [STATUS_W-1:0]  status_s2;
	logic [COUNT_W-1:0]   used_s2;
	logic                 was_s2;

	fl_cmd_t              cmd;
	fl_stat_t             stat;

	logic                 advance;
	logic [POOL_W-1:0]    pool_wr;
	logic                 blk_in_store;
	logic                 head_in_store;
	logic                 was_occ;
	logic                 do_alloc;
	logic                 do_release;
	logic [BLK_W-1:0]     granted;
	logic [STATUS_W-1:0]  status;
	logic [CNT_W-1:0]     count_d;
	logic                 occ_we;
	logic [IDX_W-1:0]     occ_wa;
	logic                 occ_wd;
	logic [IDX_W-1:0]     occ_ra;

	// The stage moves on when the result register is empty or being drained.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Pool size written through the configuration port, clamped into range.
	always_comb begin
		pool_wr = cfg_wdata;
		if (cfg_wdata == '0) begin
			pool_wr = POOL_W'(1);
		end else if (int'(cfg_wdata) > BLK_CNT) begin
			pool_wr = POOL_CAP;
		end
	end

	// A stored occupancy bit is only meaningful once the counter has passed its
	// block; blocks above it have not been handed out since the last write.
	assign blk_in_store  = int'(blk_s1) < OCC_DEPTH;
	assign head_in_store = int'(stat.head) < OCC_DEPTH;
	assign was_occ       = blk_in_store && (POOL_W'(blk_s1) < stat.fresh) && occ_rd_s1;

	// Operation decode. The empty check of a release comes before the block check.
	always_comb begin
		do_alloc   = 1'b0;
		do_release = 1'b0;
		granted    = '0;
		status     = ST_OK;
		count_d    = count_q;
		if (op_s1 == OP_ALLOC) begin
			if (stat.empty) begin
				status = ST_EMPTY;
			end else begin
				do_alloc = 1'b1;
				granted  = stat.head[BLK_W-1:0];
				count_d  = count_q + CNT_W'(1);
			end
		end else begin
			if (count_q == '0) begin
				status = ST_NONE;
			end else if ((POOL_W'(blk_s1) >= pool_q) || !was_occ) begin
				status = ST_BAD;
			end else begin
				do_release = 1'b1;
				count_d    = count_q - CNT_W'(1);
			end
		end
	end

	// Occupancy update of the operation that leaves the input register. The
	// request taken at the same edge sees this update through the bypass.
	assign occ_we = advance && ((do_alloc && head_in_store) || do_release);
	assign occ_wa = do_alloc ? stat.head[IDX_W-1:0] : blk_s1[IDX_W-1:0];
	assign occ_wd = do_alloc;
	assign occ_ra = req.block_index[IDX_W-1:0];

	assign cmd.relink      = cfg_we;
	assign cmd.pop         = advance && do_alloc;
	assign cmd.push        = advance && do_release;
	assign cmd.blk         = blk_s1;
	assign cmd.pool_blocks = pool_q;

	fbfl_free_list #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_free_list (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q   <= POOL_RST;
			count_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_q  <= pool_wr;
				count_q <= '0;
			end else if (advance) begin
				count_q <= count_d;
			end
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_wa] <= occ_wd;
		end
		if (req.ready && req.valid) begin
			op_s1  <= req.operation;
			blk_s1 <= req.block_index;
			if (occ_we && (occ_wa == occ_ra)) begin
				occ_rd_s1 <= occ_wd;
			end else begin
				occ_rd_s1 <= occ_mem[occ_ra];
			end
		end
		if (advance) begin
			granted_s2 <= granted;
			status_s2  <= status;
			used_s2    <= COUNT_W'(count_d);
			was_s2     <= was_occ;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.granted_index = granted_s2;
	assign rsp.status        = status_s2;
	assign rsp.used_count    = used_s2;
	assign rsp.was_occupied  = was_s2;

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench of the fixed block pool allocator with a LIFO free list.
`default_nettype none

// The testbench drives allocate and release requests into the unit and checks
// every response against a predictor of its own. The predictor keeps the whole
// free list as the unit's behaviour defines it: a next link per block, the head
// of the list, the number of allocated blocks and an occupancy bit per block.
//
// Requests change at the falling clock edge. A transfer is recognised at the
// rising edge, where valid and ready are both high. The expected result is
// worked out at the moment the request transfer is seen and queued. A checker
// process takes every response transfer and compares it, field by field, with
// the oldest queued expectation.
//
// The pool size register is only written while the unit is idle. That means no
// request is being offered and every expected response has come back. Every
// request gives exactly one response, so an empty queue means the unit has
// nothing in flight.
//
// Both sides pause at random in about a third of the cycles. The filling of the
// full pool runs without any pauses. One test holds the response side off for a
// long stretch, so that the unit fills up and stops taking requests.
module testbench;

	import fbfl_pkg::*;

	localparam int DEPTH        = 256;
	localparam int IDLE_PERCENT = 32;
	localparam int RUN_LIMIT    = 2_000_000;

	typedef struct packed {
		logic [BLK_W-1:0]    granted_index;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  used_count;
		logic                was_occupied;
	} alloc_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [POOL_W-1:0] cfg_wdata;

	fbfl_req_if req_ch ();
	fbfl_rsp_if rsp_ch ();

	fixed_block_free_list_allocator_unit #(
		.POOL_DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// The predictor's own copy of the free list and of the pool size.
	logic [POOL_W-1:0]  link_of [DEPTH];
	logic               in_use [DEPTH];
	logic [POOL_W-1:0]  head_blk;
	logic [COUNT_W-1:0] used_blocks;
	logic [POOL_W-1:0]  pool_size;

	// Results that are owed by the unit, in the order of their requests.
	alloc_result_t pending_results [$];

	int error_count;
	int rsp_hold_cycles;
	bit no_gaps;

	// The clock runs with a period of ten units and starts low.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// A written size of zero stands for one block. A size above the depth
	// stands for the whole depth. Blocks are chained in ascending order, and the
	// last block of the pool holds the null link, which is the depth itself.
	function automatic void relink_pool(logic [POOL_W-1:0] written);
		int size;
		size = (written == 0) ? 1 : ((written > DEPTH) ? DEPTH : int'(written));
		pool_size = POOL_W'(size);
		for (int i = 0; i < DEPTH; i++) begin
			link_of[i] = (i + 1 < size) ? POOL_W'(i + 1) : POOL_W'(DEPTH);
			in_use[i] = 1'b0;
		end
		head_blk = '0;
		used_blocks = '0;
	endfunction

	// This function applies one operation to the predicted free list and
	// returns the response that the unit owes for it. An operation that fails
	// only reports its status and leaves the list as it was.
	function automatic alloc_result_t pool_model_step(logic [OP_W-1:0] op,
			logic [BLK_W-1:0] blk);
		alloc_result_t    res;
		logic [BLK_W-1:0] got;
		res = '0;
		res.status = ST_OK;
		res.was_occupied = in_use[blk];
		if (op == OP_ALLOC) begin
			if (head_blk >= DEPTH) begin
				res.status = ST_EMPTY;
			end else begin
				got = head_blk[BLK_W-1:0];
				res.granted_index = got;
				head_blk = link_of[got];
				in_use[got] = 1'b1;
				used_blocks++;
			end
		end else if (used_blocks == 0) begin
			// An empty pool is reported before the block is checked.
			res.status = ST_NONE;
		end else if (blk >= pool_size || !in_use[blk]) begin
			res.status = ST_BAD;
		end else begin
			// The released block goes on top, so it is the next one handed out.
			link_of[blk] = head_blk;
			head_blk = POOL_W'(blk);
			in_use[blk] = 1'b0;
			used_blocks--;
		end
		res.used_count = used_blocks;
		return res;
	endfunction

	// This function returns an allocated block at random where there is one,
	// and any index otherwise.
	function automatic logic [BLK_W-1:0] pick_busy_block();
		logic [BLK_W-1:0] busy [$];
		for (int i = 0; i < DEPTH; i++) begin
			if (in_use[i]) begin
				busy.push_back(BLK_W'(i));
			end
		end
		if (busy.size() == 0) begin
			return BLK_W'($urandom_range(DEPTH - 1));
		end
		return busy[$urandom_range(busy.size() - 1)];
	endfunction

	// The send task offers one request and returns at the rising edge where it
	// is taken. The valid line is left high, so that the next request can follow
	// straight on at the next falling edge without a gap.
	task automatic send_op(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.operation   <= op;
		req_ch.block_index <= blk;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(pool_model_step(op, blk));
	endtask

	// This task withdraws the request and waits until every owed response has
	// come back. A timeout ends the run if a response never arrives.
	task automatic settle_traffic();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_pool(logic [POOL_W-1:0] value);
		settle_traffic();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		relink_pool(value);
	endtask

	// This test runs straight after reset, while the pool holds 256 blocks.
	// A release with nothing allocated comes first. Then the test covers a
	// report on a block that is in use, a release of a free block, and the
	// reuse of the block that was released last.
	task automatic test_reset_state();
		send_op(OP_RELEASE, 8'd5);
		send_op(OP_ALLOC, 8'd255);
		send_op(OP_ALLOC, 8'd0);
		send_op(OP_RELEASE, 8'd255);
		send_op(OP_RELEASE, 8'd0);
		send_op(OP_ALLOC, 8'd0);
	endtask

	// This test covers both ends of the pool size. A written zero gives a
	// single block and a written 511 gives the full depth. A pool of two
	// blocks shows the LIFO order once it has run empty.
	task automatic test_pool_limits();
		set_pool(9'd0);
		send_op(OP_ALLOC, 8'd0);
		send_op(OP_ALLOC, 8'd255);
		send_op(OP_RELEASE, 8'd1);
		send_op(OP_RELEASE, 8'd0);
		send_op(OP_RELEASE, 8'd0);
		set_pool(9'd511);
		send_op(OP_ALLOC, 8'd255);
		send_op(OP_RELEASE, 8'd200);
		set_pool(9'd2);
		send_op(OP_ALLOC, 8'd1);
		send_op(OP_ALLOC, 8'd0);
		send_op(OP_ALLOC, 8'd170);
		send_op(OP_RELEASE, 8'd1);
		send_op(OP_RELEASE, 8'd0);
		send_op(OP_ALLOC, 8'd85);
		send_op(OP_ALLOC, 8'd2);
	endtask

	// This test fills the whole pool with no pauses on either side, which
	// brings the used count to its top value. The blocks are then handed back
	// in a shuffled order.
	task automatic test_full_pool();
		int               order [DEPTH];
		int               pick;
		int               tmp;
		set_pool(9'd256);
		no_gaps = 1'b1;
		for (int i = 0; i < DEPTH; i++) begin
			send_op(OP_ALLOC, BLK_W'($urandom_range(DEPTH - 1)));
		end
		send_op(OP_ALLOC, pick_busy_block());
		settle_traffic();
		no_gaps = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			order[i] = i;
		end
		for (int i = DEPTH - 1; i > 0; i--) begin
			pick = $urandom_range(i);
			tmp = order[i];
			order[i] = order[pick];
			order[pick] = tmp;
		end
		foreach (order[i]) begin
			send_op(OP_RELEASE, BLK_W'(order[i]));
		end
		send_op(OP_RELEASE, 8'd0);
	endtask

	// This test holds the response side off for a long stretch while requests
	// keep coming. The unit must fill up, stop taking requests, and then lose
	// nothing once the response side picks up again.
	task automatic test_backpressure();
		set_pool(9'd8);
		rsp_hold_cycles = 150;
		for (int i = 0; i < 24; i++) begin
			if ($urandom_range(1) == 0) begin
				send_op(OP_ALLOC, BLK_W'($urandom_range(DEPTH - 1)));
			end else begin
				send_op(OP_RELEASE, pick_busy_block());
			end
		end
	endtask

	// Each phase of this test picks a pool size, mostly a small one so that
	// the pool runs empty and full often. It also picks how much allocates
	// outweigh releases. Most releases name a block that is in use. The rest
	// name any index, so that bad and free blocks also turn up.
	task automatic test_random_traffic(int item_total);
		int sent;
		int alloc_bias;
		int phase_len;
		sent = 0;
		while (sent < item_total) begin
			case ($urandom_range(9))
				0: begin
					set_pool(9'd256);
				end
				1: begin
					set_pool(POOL_W'($urandom_range(257, 511)));
				end
				2: begin
					set_pool(POOL_W'($urandom_range(17, 255)));
				end
				default: begin
					set_pool(POOL_W'($urandom_range(1, 16)));
				end
			endcase
			alloc_bias = $urandom_range(25, 75);
			phase_len = $urandom_range(40, 120);
			for (int i = 0; i < phase_len; i++) begin
				if ($urandom_range(99) < alloc_bias) begin
					send_op(OP_ALLOC, ($urandom_range(1) == 0) ? pick_busy_block() :
						BLK_W'($urandom_range(DEPTH - 1)));
				end else if ($urandom_range(99) < 85) begin
					send_op(OP_RELEASE, pick_busy_block());
				end else begin
					send_op(OP_RELEASE, BLK_W'($urandom_range(DEPTH - 1)));
				end
				sent++;
			end
		end
	endtask

	// The response side is ready at random, except during a hold-off and
	// during the stretch with no pauses.
	always @(negedge clk) begin
		if (rsp_hold_cycles > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold_cycles--;
		end else begin
			rsp_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Every response transfer must match the oldest expectation.
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("response transfer with no request outstanding");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.granted_index !== want.granted_index) begin
					$error("granted_index: expected %0d, got %0d",
						want.granted_index, rsp_ch.granted_index);
					error_count++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					error_count++;
				end
				if (rsp_ch.used_count !== want.used_count) begin
					$error("used_count: expected %0d, got %0d",
						want.used_count, rsp_ch.used_count);
					error_count++;
				end
				if (rsp_ch.was_occupied !== want.was_occupied) begin
					$error("was_occupied: expected %0d, got %0d",
						want.was_occupied, rsp_ch.was_occupied);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.operation   = OP_ALLOC;
		req_ch.block_index = '0;
		rsp_ch.ready       = 1'b0;
		error_count        = 0;
		rsp_hold_cycles    = 0;
		no_gaps            = 1'b0;
		relink_pool(POOL_W'(DEPTH));
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_pool_limits();
		test_backpressure();
		test_full_pool();
		test_random_traffic(1250);

		// Wait on after the queue has run empty, so that a stray extra response is
		// still caught.
		settle_traffic();
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
hdl/fbfl_pkg.sv
hdl/fbfl_req_if.sv
hdl/fbfl_rsp_if.sv
hdl/fbfl_free_list.sv
hdl/fixed_block_free_list_allocator_unit.sv
test/testbench.sv
